@@ design/epw_pkg.sv @@
// Shared types, constants and helpers for the Euler pose to world matrix block.
package epw_pkg;

  // sin/cos in Q.16, range -1.0 .. +1.0
  localparam int CS_W = 18;
  // CORDIC x, y, z working width
  localparam int CX_W = 20;
  localparam int CORDIC_STEPS = 16;

  localparam logic [18:0] A_TWO_PI = 19'd411775;
  localparam logic [18:0] A_PI = 19'd205887;
  localparam logic signed [CX_W-1:0] PI_Z = 20'sd205887;
  localparam logic signed [CX_W-1:0] HALF_PI_Z = 20'sd102944;
  localparam logic signed [CX_W-1:0] CORDIC_GAIN = 20'sd39797;
  localparam logic signed [CX_W-1:0] ONE_Z = 20'sd65536;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CALC = 1'b1;

  typedef logic signed [CS_W-1:0] cs_t;

  typedef struct packed {
    logic       v;
    logic [1:0] idx;
  } row_tag_t;

  function automatic logic [16:0] atan_tab(input logic [3:0] i);
    logic [16:0] t;
    case (i)
      4'd0: t = 17'd51472;
      4'd1: t = 17'd30386;
      4'd2: t = 17'd16055;
      4'd3: t = 17'd8150;
      4'd4: t = 17'd4091;
      4'd5: t = 17'd2047;
      4'd6: t = 17'd1024;
      4'd7: t = 17'd512;
      4'd8: t = 17'd256;
      4'd9: t = 17'd128;
      4'd10: t = 17'd64;
      4'd11: t = 17'd32;
      4'd12: t = 17'd16;
      4'd13: t = 17'd8;
      4'd14: t = 17'd4;
      4'd15: t = 17'd2;
      default: t = 17'd0;
    endcase
    return t;
  endfunction

  // Q.16 product of two sin/cos sized values, rounded half away from zero
  function automatic cs_t mulq_cs(input cs_t a, input cs_t b);
    logic signed [2*CS_W-1:0] p;
    logic [2*CS_W-1:0] mag;
    logic [2*CS_W-1:0] rm;
    logic signed [CS_W-1:0] rs;
    p = a * b;
    mag = p[2*CS_W-1] ? $unsigned(-p) : $unsigned(p);
    rm = (mag + 36'd32768) >> 16;
    rs = $signed(rm[CS_W-1:0]);
    return p[2*CS_W-1] ? -rs : rs;
  endfunction

endpackage

@@ design/epw_sincos.sv @@
// Pipelined angle reduction and 16-step CORDIC giving sine and cosine in Q.16.
module epw_sincos #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output epw_pkg::cs_t                  sin_o,
  output epw_pkg::cs_t                  cos_o
);

  localparam int AW4 = ANGLE_WIDTH + 4;
  localparam int AU = AW4 + 1;
  localparam int SH = AW4 + 20;
  localparam int MW = AW4 + 3;
  localparam int PRW = AU + MW;
  localparam int QW = AU - 16;
  localparam int QTW = QW + 19;
  localparam int NS = epw_pkg::CORDIC_STEPS;
  localparam int CW = epw_pkg::CX_W;
  localparam longint TWO_PI_L = 411775;
  localparam longint KT_L = (((longint'(1) << (AW4 - 1)) + TWO_PI_L - 1) / TWO_PI_L) * TWO_PI_L;
  localparam longint M_L = ((longint'(1) << SH) + TWO_PI_L - 1) / TWO_PI_L;
  localparam logic [AU-1:0] KT = AU'(KT_L);
  localparam logic [MW-1:0] RECIP = MW'(M_L);

  logic signed [AW4-1:0] a4;
  logic [AU-1:0]  a1_nxt, a1_r, a2_r;
  logic [PRW-1:0] prod_nxt, prod_r, qf;
  logic [QW-1:0]  q;
  logic [AU-1:0]  r_full;
  logic [18:0]    r3_nxt, r3_r;
  logic signed [CW-1:0] rw, z0_nxt;
  logic fl0_nxt;
  logic signed [CW-1:0] x_r [NS+1];
  logic signed [CW-1:0] y_r [NS+1];
  logic signed [CW-1:0] z_r [NS+1];
  logic                 fl_r [NS+1];
  logic signed [CW-1:0] x_nxt [NS];
  logic signed [CW-1:0] y_nxt [NS];
  logic signed [CW-1:0] z_nxt [NS];
  logic signed [CW-1:0] xc;
  epw_pkg::cs_t sin_nxt, cos_nxt, sin_r, cos_r;

  always_comb begin
    // offset by a multiple of 2*pi so the reduction works on a positive value
    a4 = {angle, 4'b0000};
    a1_nxt = {a4[AW4-1], a4} + KT;
    prod_nxt = PRW'(a1_r) * PRW'(RECIP);
    qf = prod_r >> SH;
    q = qf[QW-1:0];
    r_full = a2_r - AU'(QTW'(q) * QTW'(epw_pkg::A_TWO_PI));
    r3_nxt = 19'(r_full);

    rw = $signed({1'b0, r3_r});
    if (r3_r > epw_pkg::A_PI) begin
      rw = rw - $signed({1'b0, epw_pkg::A_TWO_PI});
    end
    fl0_nxt = 1'b0;
    z0_nxt = rw;
    if (rw > epw_pkg::HALF_PI_Z) begin
      z0_nxt = epw_pkg::PI_Z - rw;
      fl0_nxt = 1'b1;
    end else if (rw < -epw_pkg::HALF_PI_Z) begin
      z0_nxt = -epw_pkg::PI_Z - rw;
      fl0_nxt = 1'b1;
    end

    for (int i = 0; i < NS; i++) begin
      if (z_r[i] >= 0) begin
        x_nxt[i] = x_r[i] - (y_r[i] >>> i);
        y_nxt[i] = y_r[i] + (x_r[i] >>> i);
        z_nxt[i] = z_r[i] - $signed({3'b000, epw_pkg::atan_tab(4'(i))});
      end else begin
        x_nxt[i] = x_r[i] + (y_r[i] >>> i);
        y_nxt[i] = y_r[i] - (x_r[i] >>> i);
        z_nxt[i] = z_r[i] + $signed({3'b000, epw_pkg::atan_tab(4'(i))});
      end
    end

    xc = fl_r[NS] ? -x_r[NS] : x_r[NS];
    if (xc > epw_pkg::ONE_Z) begin
      cos_nxt = epw_pkg::cs_t'(epw_pkg::ONE_Z);
    end else if (xc < -epw_pkg::ONE_Z) begin
      cos_nxt = epw_pkg::cs_t'(-epw_pkg::ONE_Z);
    end else begin
      cos_nxt = epw_pkg::cs_t'(xc);
    end
    if (y_r[NS] > epw_pkg::ONE_Z) begin
      sin_nxt = epw_pkg::cs_t'(epw_pkg::ONE_Z);
    end else if (y_r[NS] < -epw_pkg::ONE_Z) begin
      sin_nxt = epw_pkg::cs_t'(-epw_pkg::ONE_Z);
    end else begin
      sin_nxt = epw_pkg::cs_t'(y_r[NS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a1_nxt;
      prod_r <= prod_nxt;
      a2_r <= a1_r;
      r3_r <= r3_nxt;
      x_r[0] <= epw_pkg::CORDIC_GAIN;
      y_r[0] <= '0;
      z_r[0] <= z0_nxt;
      fl_r[0] <= fl0_nxt;
      for (int i = 0; i < NS; i++) begin
        x_r[i+1] <= x_nxt[i];
        y_r[i+1] <= y_nxt[i];
        z_r[i+1] <= z_nxt[i];
        fl_r[i+1] <= fl_r[i];
      end
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

@@ design/epw_row_mac.sv @@
// Row times parent matrix pipeline with the output register of the result channel.
module epw_row_mac #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          parent_en,
  input  logic signed [VALUE_WIDTH-1:0] par [16],
  input  logic signed [VALUE_WIDTH-1:0] row_in [4],
  input  epw_pkg::row_tag_t             tag_in,
  output logic                          ready,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [1:0]                    out_row_index,
  output logic signed [VALUE_WIDTH-1:0] out_col [4],
  output logic                          out_last_row
);

  localparam int VW = VALUE_WIDTH;
  localparam int PW = 2 * VW;
  localparam int PW1 = PW + 1;
  localparam int RMW = PW - 15;
  localparam int CW = (RMW > 61) ? RMW : 61;
  localparam int SW = CW + 3;
  localparam logic [CW-1:0] LIM = CW'(1) << 60;
  localparam logic signed [SW-1:0] HI_S = SW'($signed({1'b0, {(VW-1){1'b1}}}));
  localparam logic signed [SW-1:0] LO_S = SW'($signed({1'b1, {(VW-1){1'b0}}}));

  logic signed [PW-1:0] p1_nxt [16];
  logic signed [PW-1:0] p1_r [16];
  logic signed [CW:0]   q2_nxt [16];
  logic signed [CW:0]   q2_r [16];
  logic signed [VW-1:0] row1_r [4];
  logic signed [VW-1:0] row2_r [4];
  logic signed [SW-1:0] acc [4];
  logic signed [VW-1:0] col_nxt [4];
  logic signed [VW-1:0] col_r [4];
  epw_pkg::row_tag_t t1_r, t2_r;
  logic       o_v_r;
  logic [1:0] o_idx_r;

  function automatic logic signed [CW:0] rnd(input logic signed [PW-1:0] p);
    logic [PW-1:0] mag;
    logic [PW:0]   sum;
    logic [CW-1:0] rm;
    mag = p[PW-1] ? $unsigned(-p) : $unsigned(p);
    sum = {1'b0, mag} + PW1'(32768);
    rm = CW'(sum >> 16);
    if (rm > LIM) begin
      rm = LIM;
    end
    return p[PW-1] ? -$signed({1'b0, rm}) : $signed({1'b0, rm});
  endfunction

  assign ready = !o_v_r || !out_stall;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      p1_nxt[i] = PW'(row_in[i/4]) * PW'(par[i]);
      q2_nxt[i] = rnd(p1_r[i]);
    end
    // column c sums row element k times parent entry (k, c)
    for (int c = 0; c < 4; c++) begin
      acc[c] = SW'(q2_r[c]) + SW'(q2_r[4+c]) + SW'(q2_r[8+c]) + SW'(q2_r[12+c]);
      if (!parent_en) begin
        col_nxt[c] = row2_r[c];
      end else if (acc[c] > HI_S) begin
        col_nxt[c] = HI_S[VW-1:0];
      end else if (acc[c] < LO_S) begin
        col_nxt[c] = LO_S[VW-1:0];
      end else begin
        col_nxt[c] = acc[c][VW-1:0];
      end
    end
  end

  // p1 is indexed k*4+c, so entry i uses row element i/4 and parent entry i
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      o_v_r <= 1'b0;
      o_idx_r <= '0;
    end else if (ready) begin
      t1_r <= tag_in;
      t2_r <= t1_r;
      o_v_r <= t2_r.v;
      o_idx_r <= t2_r.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      for (int i = 0; i < 16; i++) begin
        p1_r[i] <= p1_nxt[i];
        q2_r[i] <= q2_nxt[i];
      end
      for (int c = 0; c < 4; c++) begin
        row1_r[c] <= row_in[c];
        row2_r[c] <= row1_r[c];
        col_r[c] <= col_nxt[c];
      end
    end
  end

  assign out_valid = o_v_r;
  assign out_row_index = o_idx_r;
  assign out_col = col_r;
  assign out_last_row = (o_idx_r == 2'd3);

endmodule

@@ design/euler_pose_to_world_matrix.sv @@
// Top level: Euler angles and position to a 4x4 world matrix, optional parent multiply.
//
// Input channel (in_valid / in_stall): one transaction per item. A load item
// (in_cmd = load) writes one row of the parent matrix and gives no result.
// A compute item gives four result transactions, rows 0..3 in order, the
// last flagged by out_last_row. Load items can be taken every cycle while
// the output is not stalled; a compute item holds the row sequencer until
// its four rows have passed to the parent multiply. Its path: 21 sin/cos
// stages (angle reduction plus one CORDIC step per stage), 3 rotation
// stages, the row sequencer and 3 parent multiply stages. Its rows leave
// back to back while the output is not stalled.
// Configuration port (cfg_valid / cfg_ready): writes parent_enable; always
// ready. Write it only while no item is in flight.
// Reset: parent matrix returns to identity, parent_enable to 0, the pipeline
// empties. When out_stall holds a waiting result, the output and row stages
// hold; the input pipeline stops, raising in_stall, once its last item waits.
module euler_pose_to_world_matrix #(
  parameter int VALUE_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [1:0]                    in_load_row,
  input  logic signed [VALUE_WIDTH-1:0] in_load_c0,
  input  logic signed [VALUE_WIDTH-1:0] in_load_c1,
  input  logic signed [VALUE_WIDTH-1:0] in_load_c2,
  input  logic signed [VALUE_WIDTH-1:0] in_load_c3,
  input  logic signed [ANGLE_WIDTH-1:0] in_pitch_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_yaw_angle,
  input  logic signed [ANGLE_WIDTH-1:0] in_roll_angle,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_x,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_y,
  input  logic signed [VALUE_WIDTH-1:0] in_pos_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_parent_enable,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_row_index,
  output logic signed [VALUE_WIDTH-1:0] out_col0,
  output logic signed [VALUE_WIDTH-1:0] out_col1,
  output logic signed [VALUE_WIDTH-1:0] out_col2,
  output logic signed [VALUE_WIDTH-1:0] out_col3,
  output logic                          out_last_row
);

  localparam int VW = VALUE_WIDTH;
  localparam int NF = 24;
  localparam int SW = (VW > 19) ? VW : 19;
  localparam logic signed [SW-1:0] HI_S = SW'($signed({1'b0, {(VW-1){1'b1}}}));
  localparam logic signed [SW-1:0] LO_S = SW'($signed({1'b1, {(VW-1){1'b0}}}));
  localparam logic signed [VW-1:0] ONE_V =
    (VW >= 18) ? VW'(65536) : {1'b0, {(VW-1){1'b1}}};

  function automatic logic signed [VW-1:0] sat_w(input logic signed [18:0] v);
    logic signed [SW-1:0] e;
    e = SW'(v);
    if (e > HI_S) begin
      return HI_S[VW-1:0];
    end else if (e < LO_S) begin
      return LO_S[VW-1:0];
    end
    return e[VW-1:0];
  endfunction

  logic fe, ser_take, be;
  logic vf_r [NF];
  logic cmd_p_r [NF];
  logic [1:0] lrow_p_r [NF];
  logic signed [VW-1:0] d_p_r [NF][4];
  logic signed [VW-1:0] d_in [4];

  epw_pkg::cs_t sp, cp, sy, cy, sr, cr;
  epw_pkg::cs_t srp_r, crp_r, scp_r, ccp_r, cpsy_r, cpcy_r, crcy_r, crsy_r, srcy_r, srsy_r;
  epw_pkg::cs_t sy_r, cy_r, sp_r;
  epw_pkg::cs_t pa_r, pb_r, pc_r, pd_r;
  epw_pkg::cs_t scp2_r, ccp2_r, cpsy2_r, cpcy2_r, crcy2_r, crsy2_r, srcy2_r, srsy2_r, sp2_r;
  logic signed [VW-1:0] w_nxt [3][3];
  logic signed [VW-1:0] w_r [3][3];

  logic ser_v_r, ser_cmd_r;
  logic [1:0] ser_lrow_r, cnt_r;
  logic signed [VW-1:0] ser_m_r [4][4];
  logic signed [VW-1:0] ser_m_nxt [4][4];
  logic signed [VW-1:0] par_r [16];
  logic pe_r;
  epw_pkg::row_tag_t tag;
  logic signed [VW-1:0] col [4];

  assign fe = !vf_r[NF-1] || ser_take;
  assign in_stall = !fe;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_cmd == epw_pkg::CMD_LOAD) begin
      d_in[0] = in_load_c0;
      d_in[1] = in_load_c1;
      d_in[2] = in_load_c2;
      d_in[3] = in_load_c3;
    end else begin
      d_in[0] = in_pos_x;
      d_in[1] = in_pos_y;
      d_in[2] = in_pos_z;
      d_in[3] = '0;
    end
  end

  epw_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_pitch (
    .clk(clk), .en(fe), .angle(in_pitch_angle), .sin_o(sp), .cos_o(cp)
  );
  epw_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_yaw (
    .clk(clk), .en(fe), .angle(in_yaw_angle), .sin_o(sy), .cos_o(cy)
  );
  epw_sincos #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_sc_roll (
    .clk(clk), .en(fe), .angle(in_roll_angle), .sin_o(sr), .cos_o(cr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NF; i++) begin
        vf_r[i] <= 1'b0;
      end
    end else if (fe) begin
      vf_r[0] <= in_valid;
      for (int i = 1; i < NF; i++) begin
        vf_r[i] <= vf_r[i-1];
      end
    end
  end

  always_comb begin
    w_nxt[0][0] = sat_w(19'(pa_r) + 19'(crcy2_r));
    w_nxt[0][1] = sat_w(19'(scp2_r));
    w_nxt[0][2] = sat_w(19'(pb_r) - 19'(crsy2_r));
    w_nxt[1][0] = sat_w(19'(pc_r) - 19'(srcy2_r));
    w_nxt[1][1] = sat_w(19'(ccp2_r));
    w_nxt[1][2] = sat_w(19'(pd_r) + 19'(srsy2_r));
    w_nxt[2][0] = sat_w(19'(cpsy2_r));
    w_nxt[2][1] = sat_w(-(19'(sp2_r)));
    w_nxt[2][2] = sat_w(19'(cpcy2_r));
  end

  // item payload and rotation stages; sin/cos line up with the last payload stages
  always_ff @(posedge clk) begin
    if (fe) begin
      cmd_p_r[0] <= in_cmd;
      lrow_p_r[0] <= in_load_row;
      d_p_r[0] <= d_in;
      for (int i = 1; i < NF; i++) begin
        cmd_p_r[i] <= cmd_p_r[i-1];
        lrow_p_r[i] <= lrow_p_r[i-1];
        d_p_r[i] <= d_p_r[i-1];
      end
      srp_r <= epw_pkg::mulq_cs(sr, sp);
      crp_r <= epw_pkg::mulq_cs(cr, sp);
      scp_r <= epw_pkg::mulq_cs(sr, cp);
      ccp_r <= epw_pkg::mulq_cs(cr, cp);
      cpsy_r <= epw_pkg::mulq_cs(cp, sy);
      cpcy_r <= epw_pkg::mulq_cs(cp, cy);
      crcy_r <= epw_pkg::mulq_cs(cr, cy);
      crsy_r <= epw_pkg::mulq_cs(cr, sy);
      srcy_r <= epw_pkg::mulq_cs(sr, cy);
      srsy_r <= epw_pkg::mulq_cs(sr, sy);
      sy_r <= sy;
      cy_r <= cy;
      sp_r <= sp;
      pa_r <= epw_pkg::mulq_cs(srp_r, sy_r);
      pb_r <= epw_pkg::mulq_cs(srp_r, cy_r);
      pc_r <= epw_pkg::mulq_cs(crp_r, sy_r);
      pd_r <= epw_pkg::mulq_cs(crp_r, cy_r);
      scp2_r <= scp_r;
      ccp2_r <= ccp_r;
      cpsy2_r <= cpsy_r;
      cpcy2_r <= cpcy_r;
      crcy2_r <= crcy_r;
      crsy2_r <= crsy_r;
      srcy2_r <= srcy_r;
      srsy2_r <= srsy_r;
      sp2_r <= sp_r;
      w_r <= w_nxt;
    end
  end

  // row sequencer: a compute item stays for its four rows, a load item until written
  assign ser_take = !ser_v_r || (be && (ser_cmd_r == epw_pkg::CMD_LOAD || cnt_r == 2'd3));

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        ser_m_nxt[r][c] = '0;
      end
    end
    if (cmd_p_r[NF-1] == epw_pkg::CMD_LOAD) begin
      ser_m_nxt[0] = d_p_r[NF-1];
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          ser_m_nxt[r][c] = w_r[r][c];
        end
      end
      ser_m_nxt[3][0] = d_p_r[NF-1][0];
      ser_m_nxt[3][1] = d_p_r[NF-1][1];
      ser_m_nxt[3][2] = d_p_r[NF-1][2];
      ser_m_nxt[3][3] = ONE_V;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r <= 1'b0;
      cnt_r <= '0;
      pe_r <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        par_r[i] <= (i % 5 == 0) ? ONE_V : '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        pe_r <= cfg_parent_enable;
      end
      if (be && ser_v_r && ser_cmd_r == epw_pkg::CMD_LOAD) begin
        for (int c = 0; c < 4; c++) begin
          par_r[{ser_lrow_r, 2'(c)}] <= ser_m_r[0][c];
        end
      end
      if (ser_take) begin
        ser_v_r <= vf_r[NF-1];
        cnt_r <= '0;
      end else if (be && ser_v_r) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ser_take) begin
      ser_cmd_r <= cmd_p_r[NF-1];
      ser_lrow_r <= lrow_p_r[NF-1];
      ser_m_r <= ser_m_nxt;
    end
  end

  assign tag.v = ser_v_r && (ser_cmd_r == epw_pkg::CMD_CALC);
  assign tag.idx = cnt_r;

  epw_row_mac #(.VALUE_WIDTH(VALUE_WIDTH)) u_mac (
    .clk(clk),
    .rst_n(rst_n),
    .parent_en(pe_r),
    .par(par_r),
    .row_in(ser_m_r[cnt_r]),
    .tag_in(tag),
    .ready(be),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_row_index(out_row_index),
    .out_col(col),
    .out_last_row(out_last_row)
  );

  assign out_col0 = col[0];
  assign out_col1 = col[1];
  assign out_col2 = col[2];
  assign out_col3 = col[3];

endmodule

@@ design/epw_checker.sv @@
// Port level checks for the world matrix block, bound to the top level.
module epw_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_row_index,
  input logic signed [VALUE_WIDTH-1:0] out_col0,
  input logic signed [VALUE_WIDTH-1:0] out_col1,
  input logic signed [VALUE_WIDTH-1:0] out_col2,
  input logic signed [VALUE_WIDTH-1:0] out_col3,
  input logic                          out_last_row
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row_index) &&
      $stable(out_col0) && $stable(out_col1) && $stable(out_col2) && $stable(out_col3))
    else $error("stalled result transaction changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == 2'd3)))
    else $error("last row flag does not match row index");

  a_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_row |=>
      out_valid && out_row_index == $past(out_row_index) + 2'd1)
    else $error("rows of one matrix not back to back");

endmodule

bind euler_pose_to_world_matrix epw_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_epw_checker (
  .clk(clk),
  .rst_n(rst_n),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_row_index(out_row_index),
  .out_col0(out_col0),
  .out_col1(out_col1),
  .out_col2(out_col2),
  .out_col3(out_col3),
  .out_last_row(out_last_row)
);

@@ tb/euler_pose_to_world_matrix_tb.sv @@
// Testbench for euler_pose_to_world_matrix: directed and random items checked against a predictor.
`timescale 1ns / 100ps

module euler_pose_to_world_matrix_tb;

  localparam int VW = 32;
  localparam int AW = 16;
  localparam longint Q_ONE = 65536;
  localparam longint TWO_PI_Q = 411775;
  localparam longint PI_Q = 205887;
  localparam longint HALF_PI_Q = 102944;
  localparam longint GAIN_Q = 39797;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0]    row;
    logic [VW-1:0] c0;
    logic [VW-1:0] c1;
    logic [VW-1:0] c2;
    logic [VW-1:0] c3;
    logic          last;
  } world_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = epw_pkg::CMD_LOAD;
  logic [1:0] in_load_row = '0;
  logic signed [VW-1:0] in_load_c0 = '0, in_load_c1 = '0, in_load_c2 = '0, in_load_c3 = '0;
  logic signed [AW-1:0] in_pitch_angle = '0, in_yaw_angle = '0, in_roll_angle = '0;
  logic signed [VW-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_parent_enable = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_row_index;
  logic signed [VW-1:0] out_col0, out_col1, out_col2, out_col3;
  logic out_last_row;

  // predictor state
  longint parent_mat[16];
  bit parent_on;
  world_row_t rows_due[$];
  int errors = 0;

  // sink control
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_cnt = 0;
  int sink_burst = 0;

  euler_pose_to_world_matrix uut (.*);

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("euler_pose_to_world_matrix_tb failed");
    $finish;
  end

  function automatic longint sat_v(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (VW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // rounded Q.16 product, magnitude clamped to 2^60
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] ua, ub;
    logic [127:0] lim;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? 64'(-a) : 64'(a);
    ub = (b < 0) ? 64'(-b) : 64'(b);
    p = ({64'd0, ua} * {64'd0, ub} + 128'd32768) >> 16;
    lim = 128'd1 << 60;
    if (p > lim) p = lim;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  task automatic sin_cos(input logic signed [AW-1:0] ang, output longint s, output longint c);
    longint r, x, y, z, t;
    bit flip;
    r = (longint'(ang) * 16) % TWO_PI_Q;
    flip = 0;
    if (r < 0) r += TWO_PI_Q;
    if (r > PI_Q) r -= TWO_PI_Q;
    if (r > HALF_PI_Q) begin
      r = PI_Q - r;
      flip = 1;
    end else if (r < -HALF_PI_Q) begin
      r = -PI_Q - r;
      flip = 1;
    end
    x = GAIN_Q;
    y = 0;
    z = r;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= longint'(epw_pkg::atan_tab(4'(i)));
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += longint'(epw_pkg::atan_tab(4'(i)));
      end
      x = t;
    end
    if (flip) x = -x;
    if (x > Q_ONE) x = Q_ONE;
    if (x < -Q_ONE) x = -Q_ONE;
    if (y > Q_ONE) y = Q_ONE;
    if (y < -Q_ONE) y = -Q_ONE;
    s = y;
    c = x;
  endtask

  // apply one accepted transaction to the parent store or queue its four rows
  task automatic predict_world_rows();
    longint w[16], res[16], acc;
    longint sp, cp, sy, cy, sr, cr, srp, crp;
    world_row_t e;
    if (in_cmd == epw_pkg::CMD_LOAD) begin
      parent_mat[in_load_row*4 + 0] = longint'(in_load_c0);
      parent_mat[in_load_row*4 + 1] = longint'(in_load_c1);
      parent_mat[in_load_row*4 + 2] = longint'(in_load_c2);
      parent_mat[in_load_row*4 + 3] = longint'(in_load_c3);
      return;
    end
    sin_cos(in_pitch_angle, sp, cp);
    sin_cos(in_yaw_angle, sy, cy);
    sin_cos(in_roll_angle, sr, cr);
    srp = qmul(sr, sp);
    crp = qmul(cr, sp);
    w[0] = sat_v(qmul(srp, sy) + qmul(cr, cy));
    w[1] = sat_v(qmul(sr, cp));
    w[2] = sat_v(qmul(srp, cy) - qmul(cr, sy));
    w[3] = 0;
    w[4] = sat_v(qmul(crp, sy) - qmul(sr, cy));
    w[5] = sat_v(qmul(cr, cp));
    w[6] = sat_v(qmul(crp, cy) + qmul(sr, sy));
    w[7] = 0;
    w[8] = sat_v(qmul(cp, sy));
    w[9] = sat_v(-sp);
    w[10] = sat_v(qmul(cp, cy));
    w[11] = 0;
    w[12] = longint'(in_pos_x);
    w[13] = longint'(in_pos_y);
    w[14] = longint'(in_pos_z);
    w[15] = sat_v(Q_ONE);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) begin
        if (parent_on) begin
          acc = 0;
          for (int k = 0; k < 4; k++) acc += qmul(w[r*4 + k], parent_mat[k*4 + c]);
          res[r*4 + c] = sat_v(acc);
        end else begin
          res[r*4 + c] = w[r*4 + c];
        end
      end
    for (int r = 0; r < 4; r++) begin
      e.row = 2'(r);
      e.c0 = res[r*4 + 0][VW-1:0];
      e.c1 = res[r*4 + 1][VW-1:0];
      e.c2 = res[r*4 + 2][VW-1:0];
      e.c3 = res[r*4 + 3][VW-1:0];
      e.last = (r == 3);
      rows_due.push_back(e);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    world_row_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (rows_due.size() == 0) begin
        $error("unexpected result row %0d", out_row_index);
        errors++;
      end else begin
        e = rows_due.pop_front();
        if (out_row_index !== e.row) begin
          $error("row_index expected %0d got %0d", e.row, out_row_index);
          errors++;
        end
        if (out_col0 !== e.c0) begin
          $error("col0 expected %0h got %0h", e.c0, out_col0);
          errors++;
        end
        if (out_col1 !== e.c1) begin
          $error("col1 expected %0h got %0h", e.c1, out_col1);
          errors++;
        end
        if (out_col2 !== e.c2) begin
          $error("col2 expected %0h got %0h", e.c2, out_col2);
          errors++;
        end
        if (out_col3 !== e.c3) begin
          $error("col3 expected %0h got %0h", e.c3, out_col3);
          errors++;
        end
        if (out_last_row !== e.last) begin
          $error("last_row expected %0b got %0b", e.last, out_last_row);
          errors++;
        end
      end
    end
  end

  // sink stall: random bursts, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req != hold_done && hold_cnt == 0) begin
      hold_done = hold_req;
      hold_cnt = 150;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_burst = $urandom_range(0, 6);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(logic cmd, logic [1:0] lrow, logic [VW-1:0] l0, logic [VW-1:0] l1,
                           logic [VW-1:0] l2, logic [VW-1:0] l3, logic [AW-1:0] pa,
                           logic [AW-1:0] ya, logic [AW-1:0] ra, logic [VW-1:0] px,
                           logic [VW-1:0] py, logic [VW-1:0] pz);
    @(negedge clk);
    in_valid = 1'b1;
    in_cmd = cmd;
    in_load_row = lrow;
    in_load_c0 = l0;
    in_load_c1 = l1;
    in_load_c2 = l2;
    in_load_c3 = l3;
    in_pitch_angle = pa;
    in_yaw_angle = ya;
    in_roll_angle = ra;
    in_pos_x = px;
    in_pos_y = py;
    in_pos_z = pz;
    do @(posedge clk); while (in_stall);
    predict_world_rows();
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 7);
      repeat (n) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
  endtask

  task automatic compute(logic [AW-1:0] pa, logic [AW-1:0] ya, logic [AW-1:0] ra,
                         logic [VW-1:0] px, logic [VW-1:0] py, logic [VW-1:0] pz);
    send_item(epw_pkg::CMD_CALC, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
              pa, ya, ra, px, py, pz);
  endtask

  task automatic load_row(logic [1:0] r, logic [VW-1:0] a, logic [VW-1:0] b,
                          logic [VW-1:0] c, logic [VW-1:0] d);
    send_item(epw_pkg::CMD_LOAD, r, a, b, c, d, AW'($urandom), AW'($urandom), AW'($urandom),
              $urandom, $urandom, $urandom);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (rows_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_parent_enable(logic v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_parent_enable = v;
    do @(posedge clk); while (!cfg_ready);
    parent_on = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [AW-1:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return AW'($signed($urandom_range(0, 12868)) - 6434);
      1: return AW'($urandom_range(0, 3) * 6434);
      default: return AW'($urandom);
    endcase
  endfunction

  function automatic logic [VW-1:0] rand_val();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return VW'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
      default: return VW'($urandom);
    endcase
  endfunction

  task automatic random_parent();
    for (int r = 0; r < 4; r++)
      load_row(2'(r), rand_val(), rand_val(), rand_val(), rand_val());
  endtask

  // identity parent, zero angles and extremes of every field
  task automatic test_extremes();
    compute('0, '0, '0, '0, '0, '0);
    compute(16'sh7fff, 16'sh8000, 16'sh7fff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    compute(16'sh8000, 16'sh7fff, 16'sh8000, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001);
    compute(16'shffff, 16'sh0001, 16'sh1922, 32'h0001_0000, 32'hffff_0000, '0);
    // quarter and half turns land on the fold boundaries
    compute(16'sh1922, 16'sh3244, 16'shcdbc, 32'h1234_5678, 32'hedcb_a988, 32'h5555_aaaa);
    compute(16'she6de, 16'sh6488, 16'sh9b78, 32'haaaa_5555, '0, 32'h7fff_ffff);
  endtask

  task automatic test_parent_multiply();
    set_parent_enable(1'b1);
    compute('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    load_row(2'd0, 32'h0002_0000, '0, '0, '0);
    load_row(2'd1, '0, 32'hffff_0000, '0, '0);
    load_row(2'd2, '0, '0, 32'h0000_8000, 32'h0001_0000);
    load_row(2'd3, 32'h0010_0000, 32'hfff0_0000, '0, 32'h0001_0000);
    drain();
    compute(16'sh0800, 16'shf000, 16'sh2000, 32'h0100_0000, 32'hff00_0000, 32'h0000_1234);
    // saturate every product path
    drain();
    load_row(2'd0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    load_row(2'd1, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    load_row(2'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    load_row(2'd3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    drain();
    compute(16'sh0c91, 16'sh0c91, 16'sh0c91, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    compute('0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
  endtask

  // sink holds off while the sender keeps offering, then sender waits for empty
  task automatic test_backpressure();
    hold_req++;
    repeat (20) compute(rand_angle(), rand_angle(), rand_angle(), rand_val(), rand_val(),
                        rand_val());
    drain();
  endtask

  task automatic test_random(int n, bit with_loads);
    for (int i = 0; i < n; i++) begin
      if (with_loads && $urandom_range(0, 9) == 0) begin
        // loads only between matrices, so in-flight rows see a settled parent
        if (parent_on) drain();
        if ($urandom_range(0, 4) == 0) random_parent();
        else load_row(2'($urandom), rand_val(), rand_val(), rand_val(), rand_val());
        if (parent_on) drain();
      end else begin
        compute(rand_angle(), rand_angle(), rand_angle(), rand_val(), rand_val(), rand_val());
      end
      sender_gap();
    end
  endtask

  initial begin
    ref_state_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_extremes();
    test_parent_multiply();
    test_backpressure();
    set_parent_enable(1'b0);
    test_random(110, 1'b1);
    set_parent_enable(1'b1);
    random_parent();
    test_random(120, 1'b1);
    set_parent_enable(1'b0);
    test_random(60, 1'b1);
    set_parent_enable(1'b1);
    quiet = 1'b1;
    test_random(60, 1'b0);
    drain();
    if (errors == 0) begin
      $display("euler_pose_to_world_matrix_tb passed");
    end else begin
      $display("euler_pose_to_world_matrix_tb failed");
    end
    $finish;
  end

  task automatic ref_state_reset();
    for (int i = 0; i < 16; i++) parent_mat[i] = (i % 5 == 0) ? sat_v(Q_ONE) : 0;
    parent_on = 1'b0;
  endtask

endmodule

@@ euler_pose_to_world_matrix.f @@
design/epw_pkg.sv
design/epw_sincos.sv
design/epw_row_mac.sv
design/euler_pose_to_world_matrix.sv
design/epw_checker.sv
tb/euler_pose_to_world_matrix_tb.sv
